// ----- rtl/pvg_pkg.sv -----
// Package of the playfield video generator: item and result types,
// register addresses, error codes and the shared state bundle. No dependencies.
package pvg_pkg;

  localparam int unsigned PatWidth   = 40;
  localparam int unsigned LeftWidth  = 20;
  localparam int unsigned PosWidth   = 6;

  localparam logic [7:0] HblankReset = 8'd68;
  localparam logic [3:0] SyncReset   = 4'd3;
  localparam logic [7:0] BlankBadBits = 8'h3C;

  typedef enum logic [0:0] {
    CFG_HBLANK = 1'b0,
    CFG_SYNC   = 1'b1
  } pvg_cfg_e;

  typedef enum logic [0:0] {
    KIND_TICK  = 1'b0,
    KIND_WRITE = 1'b1
  } pvg_kind_e;

  typedef enum logic [5:0] {
    ADDR_VSYNC  = 6'h00,
    ADDR_VBLANK = 6'h01,
    ADDR_WSYNC  = 6'h02,
    ADDR_COLUPF = 6'h08,
    ADDR_COLUBK = 6'h09,
    ADDR_CTRLPF = 6'h0A,
    ADDR_PF0    = 6'h0D,
    ADDR_PF1    = 6'h0E,
    ADDR_PF2    = 6'h0F
  } pvg_addr_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_NO_SYNC    = 3'd1,
    ERR_SYNC_LONG  = 3'd2,
    ERR_BAD_SYNC   = 3'd3,
    ERR_BAD_BLANK  = 3'd4,
    ERR_UNMAPPED   = 3'd5
  } pvg_err_e;

  typedef struct packed {
    logic       kind;
    logic [5:0] reg_addr;
    logic [7:0] reg_value;
    logic [7:0] beam_x;
    logic [8:0] beam_y;
  } pvg_item_t;

  typedef struct packed {
    logic       pixel_valid;
    logic       pixel_blank;
    logic [7:0] pixel_color;
    logic       halt_request;
    pvg_err_e   error_code;
  } pvg_result_t;

  // Programmed state seen by the pixel path
  typedef struct packed {
    logic [7:0]           hblank_clocks;
    logic [3:0]           sync_line_count;
    logic [LeftWidth-1:0] left_pattern;
    logic                 reflect_flag;
    logic [7:0]           fore_color;
    logic [7:0]           back_color;
    logic                 sync_active;
    logic                 blank_active;
  } pvg_state_t;

endpackage

// ----- rtl/pvg_if.sv -----
// Valid/ready stream interfaces for the input items and the result items.
// Depends on nothing.
interface pvg_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [5:0] reg_addr;
  logic [7:0] reg_value;
  logic [7:0] beam_x;
  logic [8:0] beam_y;

  modport source (output valid, kind, reg_addr, reg_value, beam_x, beam_y, input ready);
  modport sink   (input valid, kind, reg_addr, reg_value, beam_x, beam_y, output ready);
endinterface

interface pvg_out_if;
  logic       valid;
  logic       ready;
  logic       pixel_valid;
  logic       pixel_blank;
  logic [7:0] pixel_color;
  logic       halt_request;
  logic [2:0] error_code;

  modport source (output valid, pixel_valid, pixel_blank, pixel_color, halt_request,
                  error_code, input ready);
  modport sink   (input valid, pixel_valid, pixel_blank, pixel_color, halt_request,
                  error_code, output ready);
endinterface

// ----- rtl/playfield_video_generator.sv -----
// Top level of the playfield video generator: register file, pixel path and
// result buffer. Depends on pvg_pkg, pvg_if, pvg_regs, pvg_pixel, pvg_out_buf.
//
// Usage:
//   in_i  carries items: a register write (kind 1: reg_addr, reg_value) or a
//         pixel-clock tick (kind 0: beam_x, beam_y). Every item gives exactly
//         one result item on out_o.
//   out_o carries results: pixel_valid/pixel_blank/pixel_color for ticks,
//         halt_request for a wait-for-sync write, error_code for both.
//   cfg_*  write hblank_clocks (index 0) and sync_line_count (index 1); write
//         them only while no item is in flight.
// Timing: the result of an item is registered at the edge that accepts it.
//   Throughput: one item per cycle while out_o.ready is high, set by the
//   single combinational pass between input handshake and output register.
// Reset: all chip registers clear, hblank_clocks returns to 68 and
//   sync_line_count to 3, the result buffer empties.
// Stall: a result waiting at the output is held; one more item is taken into
//   the skid register, after which in_i.ready drops until the receiver drains.
module playfield_video_generator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  pvg_in_if.sink     in_i,
  pvg_out_if.source  out_o
);
  import pvg_pkg::*;

  pvg_item_t   item;
  pvg_state_t  state;
  pvg_result_t wr_res, px_res, res;
  pvg_result_t out_res;
  logic        in_ready, accept;

  // Gather the payload of the input channel
  assign item = '{kind: in_i.kind, reg_addr: in_i.reg_addr, reg_value: in_i.reg_value,
                  beam_x: in_i.beam_x, beam_y: in_i.beam_y};

  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  // Chip registers advance on an accepted write; ticks read the old state
  pvg_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .item_i     (item),
    .state_o    (state),
    .wr_res_o   (wr_res)
  );

  pvg_pixel u_pixel (
    .item_i   (item),
    .state_i  (state),
    .px_res_o (px_res)
  );

  // Select the result by item kind
  assign res = (item.kind == KIND_WRITE) ? wr_res : px_res;

  pvg_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .in_res_i    (res),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_res_o   (out_res)
  );

  assign out_o.pixel_valid  = out_res.pixel_valid;
  assign out_o.pixel_blank  = out_res.pixel_blank;
  assign out_o.pixel_color  = out_res.pixel_color;
  assign out_o.halt_request = out_res.halt_request;
  assign out_o.error_code   = out_res.error_code;

  a_tick_no_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.pixel_valid) |-> !out_o.halt_request)
    else $error("tick result raised halt request");
  a_blank_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.pixel_blank) |-> (out_o.pixel_color == 8'd0 && out_o.pixel_valid))
    else $error("blank pixel carries colour");
  a_write_no_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.pixel_valid) |-> (out_o.pixel_color == 8'd0 && !out_o.pixel_blank))
    else $error("write result carries pixel data");

endmodule

// ----- rtl/pvg_regs.sv -----
// Configuration and chip register file of the playfield video generator,
// with the write decoder. Depends on pvg_pkg.
module pvg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                accept_i,
  input  pvg_pkg::pvg_item_t  item_i,
  output pvg_pkg::pvg_state_t state_o,
  output pvg_pkg::pvg_result_t wr_res_o
);
  import pvg_pkg::*;

  pvg_state_t state_d, state_q;
  pvg_result_t res;

  always_comb begin
    state_d = state_q;
    res     = '{pixel_valid: 1'b0, pixel_blank: 1'b0, pixel_color: 8'd0,
                halt_request: 1'b0, error_code: ERR_NONE};
    case (item_i.reg_addr)
      ADDR_VSYNC: begin
        if (item_i.reg_value != 8'd0 && item_i.reg_value != 8'd2) begin
          res.error_code = ERR_BAD_SYNC;
        end else begin
          state_d.sync_active = item_i.reg_value[1];
        end
      end
      ADDR_VBLANK: begin
        if ((item_i.reg_value & BlankBadBits) != 8'd0) begin
          res.error_code = ERR_BAD_BLANK;
        end else begin
          state_d.blank_active = item_i.reg_value[1];
        end
      end
      ADDR_WSYNC:  res.halt_request = 1'b1;
      ADDR_COLUPF: state_d.fore_color = item_i.reg_value;
      ADDR_COLUBK: state_d.back_color = item_i.reg_value;
      ADDR_CTRLPF: state_d.reflect_flag = item_i.reg_value[0];
      ADDR_PF0:    state_d.left_pattern[3:0] = item_i.reg_value[7:4];
      ADDR_PF1:    state_d.left_pattern[11:4] = item_i.reg_value;
      ADDR_PF2:    state_d.left_pattern[19:12] = item_i.reg_value;
      default:     res.error_code = ERR_UNMAPPED;
    endcase
    // Only a write item may touch the chip registers
    if (!(accept_i && item_i.kind == KIND_WRITE)) begin
      state_d = state_q;
    end
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HBLANK: state_d.hblank_clocks   = cfg_data_i;
        CFG_SYNC:   state_d.sync_line_count = cfg_data_i[3:0];
        default:    state_d = state_d;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{hblank_clocks: HblankReset, sync_line_count: SyncReset,
                   left_pattern: '0, reflect_flag: 1'b0, fore_color: 8'd0,
                   back_color: 8'd0, sync_active: 1'b0, blank_active: 1'b0};
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o  = state_q;
  assign wr_res_o = res;

endmodule

// ----- rtl/pvg_pixel.sv -----
// Pixel path: sync-length check, blanking, playfield pattern lookup and
// colour selection for one tick. Depends on pvg_pkg.
module pvg_pixel (
  input  pvg_pkg::pvg_item_t   item_i,
  input  pvg_pkg::pvg_state_t  state_i,
  output pvg_pkg::pvg_result_t px_res_o
);
  import pvg_pkg::*;

  logic [LeftWidth-1:0] right_pat;
  logic [PatWidth-1:0]  line_pat;
  logic [7:0]           vis_x;
  logic [PosWidth-1:0]  pos;
  logic                 pf_hit;
  logic [8:0]           slc_ext;

  always_comb begin
    for (int k = 0; k < LeftWidth; k++) begin
      right_pat[k] = state_i.reflect_flag ? state_i.left_pattern[LeftWidth-1-k]
                                          : state_i.left_pattern[k];
    end
  end

  assign line_pat = {right_pat, state_i.left_pattern};
  assign vis_x    = item_i.beam_x - state_i.hblank_clocks;
  assign pos      = vis_x[7:2];
  assign pf_hit   = (item_i.beam_x >= state_i.hblank_clocks) &&
                    (pos < PosWidth'(PatWidth)) && line_pat[pos];
  assign slc_ext  = {5'd0, state_i.sync_line_count};

  always_comb begin
    px_res_o = '{pixel_valid: 1'b1, pixel_blank: 1'b0, pixel_color: 8'd0,
                 halt_request: 1'b0, error_code: ERR_NONE};
    if (item_i.beam_y != 9'd0 && item_i.beam_y < slc_ext && !state_i.sync_active) begin
      px_res_o.error_code = ERR_NO_SYNC;
    end else if (item_i.beam_y > slc_ext && state_i.sync_active) begin
      px_res_o.error_code = ERR_SYNC_LONG;
    end
    if (state_i.blank_active) begin
      px_res_o.pixel_blank = 1'b1;
    end else begin
      px_res_o.pixel_color = pf_hit ? state_i.fore_color : state_i.back_color;
    end
  end

endmodule

// ----- rtl/pvg_out_buf.sv -----
// Two-entry result buffer: output register plus skid register, so the input
// side never waits on the receiver combinationally. Depends on pvg_pkg.
module pvg_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pvg_pkg::pvg_result_t in_res_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pvg_pkg::pvg_result_t out_res_o
);
  import pvg_pkg::*;

  logic        out_v_q, out_v_d, skid_v_q, skid_v_d;
  pvg_result_t out_q, out_d, skid_q, skid_d;
  logic        in_fire, out_fire;

  assign in_ready_o = !skid_v_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_v_q && out_ready_i;

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (out_fire) begin
      if (skid_v_q) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end else begin
        out_v_d = in_fire;
        out_d   = in_res_i;
      end
    end else if (!out_v_q) begin
      out_v_d = in_fire;
      out_d   = in_res_i;
    end else if (in_fire) begin
      skid_v_d = 1'b1;
      skid_d   = in_res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid entry without output entry");
  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && out_v_q && !out_ready_i) |=> skid_v_q)
    else $error("item lost while output stalled");
  a_skid_drains_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && skid_v_q) |=> (out_v_q && out_q == $past(skid_q)))
    else $error("skid entry not moved to output");

endmodule
